### rtl/osm_pkg.sv
`default_nettype none
package osm_pkg;

  // Command codes
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_RANK   = 3'd2;
  localparam logic [2:0] CMD_SELECT = 3'd3;
  localparam logic [2:0] CMD_PRED   = 3'd4;
  localparam logic [2:0] CMD_SUCC   = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ABSENT    = 3'd1;
  localparam logic [2:0] ST_BAD_RANK  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  localparam logic signed [31:0] KEY_LOWEST  = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_HIGHEST = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic        [2:0]  command;
    logic signed [31:0] operand;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic        [2:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INC,
    CELL_DEC,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef enum logic [1:0] {
    SCAN_RANK,
    SCAN_SELECT,
    SCAN_PRED,
    SCAN_SUCC
  } scan_mode_t;

  typedef struct packed {
    cell_op_t   op;
    scan_mode_t mode;
  } cell_ctl_t;

  // Wave that travels down the chain during a query
  typedef struct packed {
    logic               found;
    logic signed [31:0] key;
  } scan_pkt_t;

endpackage
`default_nettype wire

### rtl/osm_cell.sv
`default_nettype none
module osm_cell #(
  parameter int KEY_BITS   = 32,
  parameter int COUNT_BITS = 16,
  parameter int SW         = 33
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire osm_pkg::cell_ctl_t      ctl,
  input  wire logic signed [KEY_BITS-1:0] cmd_key,
  input  wire logic [SW-1:0]           rank,
  input  wire logic                    left_below,
  input  wire logic signed [KEY_BITS-1:0] left_key,
  input  wire logic [COUNT_BITS-1:0]   left_cnt,
  input  wire logic signed [KEY_BITS-1:0] right_key,
  input  wire logic [COUNT_BITS-1:0]   right_cnt,
  input  wire logic [SW-1:0]           sum_in,
  input  wire osm_pkg::scan_pkt_t      pkt_in,
  output logic signed [KEY_BITS-1:0]   key_o,
  output logic [COUNT_BITS-1:0]        cnt_o,
  output logic                         below_o,
  output logic                         eq_o,
  output logic                         sat_o,
  output logic                         single_o,
  output logic [SW-1:0]                sum_o,
  output osm_pkg::scan_pkt_t           pkt_o
);

  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [COUNT_BITS-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]              sum_r, sum_nxt;
  osm_pkg::scan_pkt_t         pkt_r, pkt_nxt;
  logic                       occ;
  logic signed [31:0]         key_ext;

  assign occ      = (cnt_r != '0);
  assign below_o  = occ && (key_r < cmd_key);
  assign eq_o     = occ && (key_r == cmd_key);
  assign sat_o    = eq_o && (&cnt_r);
  assign single_o = eq_o && (cnt_r == COUNT_BITS'(1));
  assign key_ext  = 32'(key_r);
  assign key_o    = key_r;
  assign cnt_o    = cnt_r;
  assign sum_o    = sum_r;
  assign pkt_o    = pkt_r;

  // Storage update: count up or down in the matching cell, or shift toward or away from the insertion point
  always_comb begin
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    case (ctl.op)
      osm_pkg::CELL_INC: begin
        if (eq_o) cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
      osm_pkg::CELL_DEC: begin
        if (eq_o) cnt_nxt = cnt_r - COUNT_BITS'(1);
      end
      osm_pkg::CELL_INSERT: begin
        if (!below_o) begin
          if (left_below) begin
            key_nxt = cmd_key;
            cnt_nxt = COUNT_BITS'(1);
          end else begin
            key_nxt = left_key;
            cnt_nxt = left_cnt;
          end
        end
      end
      osm_pkg::CELL_DELETE: begin
        if (!below_o) begin
          key_nxt = right_key;
          cnt_nxt = right_cnt;
        end
      end
      default: ;
    endcase
  end

  // Scan wave: take the left neighbor's packet and add this cell's part
  always_comb begin
    sum_nxt = sum_in;
    pkt_nxt = pkt_in;
    case (ctl.mode)
      osm_pkg::SCAN_RANK: begin
        if (below_o) sum_nxt = sum_in + SW'(cnt_r);
      end
      osm_pkg::SCAN_SELECT: begin
        sum_nxt = sum_in + SW'(cnt_r);
        if (!pkt_in.found && occ && (sum_nxt >= rank)) begin
          pkt_nxt.found = 1'b1;
          pkt_nxt.key   = key_ext;
        end
      end
      osm_pkg::SCAN_PRED: begin
        if (below_o) pkt_nxt.key = key_ext;
      end
      default: begin
        if (!pkt_in.found && occ && (key_r > cmd_key)) begin
          pkt_nxt.found = 1'b1;
          pkt_nxt.key   = key_ext;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    key_r <= key_nxt;
    sum_r <= sum_nxt;
    pkt_r <= pkt_nxt;
  end

endmodule
`default_nettype wire

### rtl/order_statistic_multiset_core.sv
`default_nettype none
// Ordered multiset with rank and select.
// Input channel: in_item (command, operand) with in_valid / in_stall; a transfer
// happens on a clock edge with in_valid high and in_stall low. Output channel:
// out_item (answer, status) with out_valid / out_stall, one result per command.
// Storage is a chain of DISTINCT_CAPACITY cells kept in ascending key order;
// every cell compares its key with the command key at once, so add and remove
// update the whole chain together. Queries (rank, select, predecessor, successor)
// send a wave down the chain, one cell per cycle.
// Add, remove, unused commands and a bad select rank go from the execute state
// straight to the finish state; rank, select, predecessor and successor scan
// the chain in between.
// One command is in flight at a time; the next is taken in the idle state after
// the result moves to the output register. The chain length sets the query time.
// Reset (rst_n low, synchronous) empties the store and drops any pending result.
// While out_stall is high the result is held and the next command may already
// run; its result waits in the finish state until the output register frees.
module order_statistic_multiset_core #(
  parameter int DISTINCT_CAPACITY = 256,
  parameter int KEY_BITS          = 32,
  parameter int COUNT_BITS        = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire osm_pkg::in_item_t in_item,
  output logic                out_valid,
  input  wire logic           out_stall,
  output osm_pkg::out_item_t  out_item
);

  localparam int N    = DISTINCT_CAPACITY;
  localparam int SRAW = COUNT_BITS + $clog2(N) + 1;
  localparam int SW   = (SRAW > 33) ? SRAW : 33;
  localparam int DW   = $clog2(N + 1);
  localparam int CW   = $clog2(N);

  typedef enum logic [1:0] {IDLE, EXEC, SCAN, DONE} state_t;

  state_t                     state_r;
  logic [2:0]                 cmd_r;
  logic signed [31:0]         op_r;
  logic [DW-1:0]              distinct_r;
  logic [SW-1:0]              total_r;
  logic [CW-1:0]              scan_cnt_r;
  logic signed [31:0]         ans_r;
  logic [2:0]                 stat_r;
  logic                       out_valid_r;
  osm_pkg::out_item_t         out_item_r;

  logic signed [KEY_BITS-1:0] cmd_key;
  logic [SW-1:0]              rank_val;
  osm_pkg::cell_ctl_t         ctl;
  logic [2:0]                 exec_status;
  logic                       hit, sat, single, full, bad_rank;

  logic signed [KEY_BITS-1:0] key_a [N];
  logic [COUNT_BITS-1:0]      cnt_a [N];
  logic [SW-1:0]              sum_a [N];
  osm_pkg::scan_pkt_t         pkt_a [N];
  logic [N-1:0]               below_v, eq_v, sat_v, single_v;

  assign cmd_key  = op_r[KEY_BITS-1:0];
  assign rank_val = SW'($unsigned(op_r));
  assign hit      = |eq_v;
  assign sat      = |sat_v;
  assign single   = |single_v;
  assign full     = (distinct_r == DW'(N));
  assign bad_rank = op_r[31] || (op_r == '0) || (rank_val > total_r);

  assign in_stall  = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Decide the scan mode, and the cell operation and status of add and remove
  always_comb begin
    ctl.op      = osm_pkg::CELL_HOLD;
    exec_status = osm_pkg::ST_OK;
    unique case (cmd_r)
      osm_pkg::CMD_RANK:   ctl.mode = osm_pkg::SCAN_RANK;
      osm_pkg::CMD_SELECT: ctl.mode = osm_pkg::SCAN_SELECT;
      osm_pkg::CMD_PRED:   ctl.mode = osm_pkg::SCAN_PRED;
      default:             ctl.mode = osm_pkg::SCAN_SUCC;
    endcase
    if (cmd_r == osm_pkg::CMD_ADD) begin
      if (hit) begin
        if (sat) exec_status = osm_pkg::ST_SATURATED;
        else     ctl.op      = osm_pkg::CELL_INC;
      end else if (full) begin
        exec_status = osm_pkg::ST_FULL;
      end else begin
        ctl.op = osm_pkg::CELL_INSERT;
      end
    end else if (cmd_r == osm_pkg::CMD_REMOVE) begin
      if (!hit)        exec_status = osm_pkg::ST_ABSENT;
      else if (single) ctl.op      = osm_pkg::CELL_DELETE;
      else             ctl.op      = osm_pkg::CELL_DEC;
    end
    if (state_r != EXEC) ctl.op = osm_pkg::CELL_HOLD;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                       l_below;
    logic signed [KEY_BITS-1:0] l_key, r_key;
    logic [COUNT_BITS-1:0]      l_cnt, r_cnt;
    logic [SW-1:0]              s_in;
    osm_pkg::scan_pkt_t         p_in;

    if (i == 0) begin : g_head
      assign l_below    = 1'b1;
      assign l_key      = '0;
      assign l_cnt      = '0;
      assign s_in       = '0;
      assign p_in.found = 1'b0;
      assign p_in.key   = (ctl.mode == osm_pkg::SCAN_PRED) ? osm_pkg::KEY_LOWEST :
                          (ctl.mode == osm_pkg::SCAN_SUCC) ? osm_pkg::KEY_HIGHEST : '0;
    end else begin : g_link
      assign l_below = below_v[i-1];
      assign l_key   = key_a[i-1];
      assign l_cnt   = cnt_a[i-1];
      assign s_in    = sum_a[i-1];
      assign p_in    = pkt_a[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_key = '0;
      assign r_cnt = '0;
    end else begin : g_next
      assign r_key = key_a[i+1];
      assign r_cnt = cnt_a[i+1];
    end

    osm_cell #(
      .KEY_BITS  (KEY_BITS),
      .COUNT_BITS(COUNT_BITS),
      .SW        (SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .cmd_key   (cmd_key),
      .rank      (rank_val),
      .left_below(l_below),
      .left_key  (l_key),
      .left_cnt  (l_cnt),
      .right_key (r_key),
      .right_cnt (r_cnt),
      .sum_in    (s_in),
      .pkt_in    (p_in),
      .key_o     (key_a[i]),
      .cnt_o     (cnt_a[i]),
      .below_o   (below_v[i]),
      .eq_o      (eq_v[i]),
      .sat_o     (sat_v[i]),
      .single_o  (single_v[i]),
      .sum_o     (sum_a[i]),
      .pkt_o     (pkt_a[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      distinct_r  <= '0;
      total_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // raise the result from the finish state; drop it once the receiver takes it
      if (state_r == DONE && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)                   out_valid_r <= 1'b0;
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_item.command;
            op_r    <= in_item.operand;
            state_r <= EXEC;
          end
        end
        EXEC: begin
          ans_r      <= '0;
          stat_r     <= exec_status;
          scan_cnt_r <= '0;
          state_r    <= DONE;
          case (cmd_r)
            osm_pkg::CMD_ADD: begin
              if (exec_status == osm_pkg::ST_OK) total_r <= total_r + SW'(1);
              if (ctl.op == osm_pkg::CELL_INSERT) distinct_r <= distinct_r + DW'(1);
            end
            osm_pkg::CMD_REMOVE: begin
              if (exec_status == osm_pkg::ST_OK) total_r <= total_r - SW'(1);
              if (ctl.op == osm_pkg::CELL_DELETE) distinct_r <= distinct_r - DW'(1);
            end
            osm_pkg::CMD_SELECT: begin
              if (bad_rank) stat_r  <= osm_pkg::ST_BAD_RANK;
              else          state_r <= SCAN;
            end
            osm_pkg::CMD_RANK, osm_pkg::CMD_PRED, osm_pkg::CMD_SUCC: begin
              state_r <= SCAN;
            end
            default: ;
          endcase
        end
        SCAN: begin
          // advance the wave until it leaves the last cell
          scan_cnt_r <= scan_cnt_r + CW'(1);
          if (scan_cnt_r == CW'(N - 1)) begin
            if (cmd_r == osm_pkg::CMD_RANK) ans_r <= 32'(sum_a[N-1] + SW'(1));
            else                            ans_r <= pkt_a[N-1].key;
            state_r <= DONE;
          end
        end
        default: begin
          // hold the result until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_item_r.answer <= ans_r;
            out_item_r.status <= stat_r;
            state_r           <= IDLE;
          end
        end
      endcase
    end
  end

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == DONE))
    else $error("result raised outside finish state");

  a_distinct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r <= DW'(N))
    else $error("distinct count exceeds capacity");

  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    (distinct_r == '0) == (total_r == '0))
    else $error("distinct and total counts disagree on empty");

  a_store_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SCAN) |=> $stable(distinct_r) && $stable(total_r))
    else $error("store changed during a query");

endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;

  localparam int CAP       = 256;
  localparam int COUNT_MAX = 65535;
  localparam int LAT       = CAP + 8;
  localparam int IDLE_LIMIT = 20000;

  // Command codes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  osm_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  osm_pkg::out_item_t out_item;

  order_statistic_multiset_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #2 clk = ~clk;

  // Shadow copy of the sorted store: distinct keys ascending with their counts.
  logic signed [31:0] shadow_key[$];
  int unsigned        shadow_cnt[$];
  longint unsigned    shadow_total;

  osm_pkg::out_item_t pending_answers[$];
  int  mismatches = 0;
  bit  failed = 1'b0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  // Position of the first stored key not below k.
  function automatic int slot_of(logic signed [31:0] k);
    int n;
    n = 0;
    while (n < shadow_key.size() && shadow_key[n] < k) n++;
    return n;
  endfunction

  // Apply one command to the shadow store and return the expected result.
  function automatic osm_pkg::out_item_t apply_command(osm_pkg::in_item_t it);
    osm_pkg::out_item_t r;
    int pos;
    bit hit;
    longint unsigned acc;
    pos = slot_of(it.operand);
    hit = pos < shadow_key.size() && shadow_key[pos] == it.operand;
    r.answer = '0;
    r.status = osm_pkg::ST_OK;
    case (it.command)
      osm_pkg::CMD_ADD: begin
        if (hit) begin
          if (shadow_cnt[pos] >= COUNT_MAX) r.status = osm_pkg::ST_SATURATED;
          else begin
            shadow_cnt[pos]++;
            shadow_total++;
          end
        end else if (shadow_key.size() >= CAP) begin
          r.status = osm_pkg::ST_FULL;
        end else begin
          shadow_key.insert(pos, it.operand);
          shadow_cnt.insert(pos, 1);
          shadow_total++;
        end
      end
      osm_pkg::CMD_REMOVE: begin
        if (!hit) r.status = osm_pkg::ST_ABSENT;
        else begin
          if (shadow_cnt[pos] > 1) shadow_cnt[pos]--;
          else begin
            shadow_key.delete(pos);
            shadow_cnt.delete(pos);
          end
          shadow_total--;
        end
      end
      osm_pkg::CMD_RANK: begin
        acc = 1;
        for (int i = 0; i < pos; i++) acc += shadow_cnt[i];
        r.answer = acc[31:0];
      end
      osm_pkg::CMD_SELECT: begin
        if (it.operand < 1 || longint'(it.operand) > shadow_total)
          r.status = osm_pkg::ST_BAD_RANK;
        else begin
          acc = 0;
          for (int i = 0; i < shadow_key.size(); i++) begin
            acc += shadow_cnt[i];
            if (acc >= it.operand) begin
              r.answer = shadow_key[i];
              break;
            end
          end
        end
      end
      osm_pkg::CMD_PRED: r.answer = pos > 0 ? shadow_key[pos-1] : osm_pkg::KEY_LOWEST;
      osm_pkg::CMD_SUCC: begin
        if (hit) pos++;
        r.answer = pos < shadow_key.size() ? shadow_key[pos] : osm_pkg::KEY_HIGHEST;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one command after a random gap and hold it until the transfer.
  // Valid drops between transfers; the block stalls its input after each
  // transfer anyway.
  task automatic send_command(logic [2:0] c, logic signed [31:0] v, bit no_gap = 1'b0);
    osm_pkg::in_item_t it;
    int gap;
    it.command = c;
    it.operand = v;
    gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
    if (no_gap || gap == 0) gap = 1;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pending_answers.push_back(apply_command(it));
    in_valid <= 1'b0;
  endtask

  // Receiver: draw a stall length per result; honor long hold-offs.
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      wait_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
      if (wait_n > 0 || hold_off) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    osm_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d", out_item.answer,
                                       out_item.status);
      end else begin
        e = pending_answers.pop_front();
        if (e.answer !== out_item.answer || e.status !== out_item.status) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected answer %0d status %0d, got %0d status %0d",
                     e.answer, e.status, out_item.answer, out_item.status);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic logic signed [31:0] near_key();
    return $signed($urandom_range(0, 40)) - 20;
  endfunction

  task automatic test_extremes();
    send_command(osm_pkg::CMD_PRED, 0);
    send_command(osm_pkg::CMD_SUCC, 0);
    send_command(osm_pkg::CMD_SELECT, 1);
    send_command(osm_pkg::CMD_REMOVE, 5);
    send_command(osm_pkg::CMD_ADD, osm_pkg::KEY_LOWEST);
    send_command(osm_pkg::CMD_ADD, osm_pkg::KEY_HIGHEST);
    send_command(osm_pkg::CMD_ADD, 0);
    send_command(osm_pkg::CMD_ADD, 0);
    send_command(osm_pkg::CMD_ADD, -1);
    send_command(osm_pkg::CMD_RANK, osm_pkg::KEY_HIGHEST);
    send_command(osm_pkg::CMD_RANK, osm_pkg::KEY_LOWEST);
    send_command(osm_pkg::CMD_SELECT, 0);
    send_command(osm_pkg::CMD_SELECT, -1);
    send_command(osm_pkg::CMD_SELECT, osm_pkg::KEY_LOWEST);
    send_command(osm_pkg::CMD_SELECT, 5);
    send_command(osm_pkg::CMD_SELECT, 6);
    send_command(osm_pkg::CMD_PRED, osm_pkg::KEY_LOWEST);
    send_command(osm_pkg::CMD_SUCC, osm_pkg::KEY_HIGHEST);
    send_command(osm_pkg::CMD_SUCC, 0);
    send_command(osm_pkg::CMD_PRED, 0);
    send_command(CMD_SPARE_A, 7);
    send_command(CMD_SPARE_B, -7);
    send_command(osm_pkg::CMD_REMOVE, 0);
    send_command(osm_pkg::CMD_REMOVE, osm_pkg::KEY_HIGHEST);
  endtask

  // Fill every slot, then overflow it; drain again.
  task automatic test_full_store();
    for (int i = 0; i < CAP + 4; i++) send_command(osm_pkg::CMD_ADD, 1000 + i);
    send_command(osm_pkg::CMD_SUCC, 1000);
    for (int i = 0; i < CAP + 4; i++) send_command(osm_pkg::CMD_REMOVE, 1000 + i);
  endtask

  // Receiver holds off for a long stretch while adds keep coming, so the
  // block backs up and stalls its input.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_command(osm_pkg::CMD_ADD, 77, 1'b1);
    join
    send_command(osm_pkg::CMD_SELECT, 40);
    send_command(osm_pkg::CMD_RANK, 78);
    for (int i = 0; i < 40; i++) send_command(osm_pkg::CMD_REMOVE, 77, 1'b1);
  endtask

  // Mostly clustered keys so hits happen; some wide random operands.
  task automatic test_random();
    logic [2:0] c;
    logic signed [31:0] v;
    for (int n = 0; n < 720; n++) begin
      c = $urandom_range(0, 9) == 0 ? 3'($urandom_range(0, 7))
                                    : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 5) == 0) v = $urandom;
      else if (c == osm_pkg::CMD_SELECT)
        v = $signed($urandom_range(0, 32'(shadow_total) + 32'd2));
      else v = near_key();
      send_command(c, v);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_full_store();
    test_backpressure();
    test_random();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    if (!failed && pending_answers.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
